// ----- rtl/fwu_pkg.sv -----
// ----------------------------------------------------------------------------
// fwu_pkg: firmware upload sequencer shared definitions
// Field widths, event and packet codes, status codes, register indexes and
// the default parameter values of the sequencer.
// ----------------------------------------------------------------------------
package fwu_pkg;

  // field widths
  localparam int unsigned SIZE_W = 21;
  localparam int unsigned CRC_W  = 16;
  localparam int unsigned READ_W = 20;
  localparam int unsigned STAT_W = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // default parameter values
  localparam int unsigned CHUNK_BYTES_DEF         = 200;
  localparam int unsigned RETRY_LIMIT_DEF         = 5;
  localparam int unsigned REPLY_TIMEOUT_TICKS_DEF = 350;
  localparam int unsigned START_TIMEOUT_TICKS_DEF = 500;

  // image size limit and target offsets
  localparam logic [SIZE_W-1:0] MAX_IMAGE_BYTES = SIZE_W'(1048576);
  localparam logic [SIZE_W-1:0] BOOT_OFFSET     = SIZE_W'(1024 * 2 * 50);
  localparam logic [SIZE_W-1:0] APP_OFFSET      = SIZE_W'(6);

  // event kinds
  typedef enum logic [1:0] {
    EV_START  = 2'd0,
    EV_TICK   = 2'd1,
    EV_REPLY  = 2'd2,
    EV_CANCEL = 2'd3
  } event_kind_e;

  // packet kinds
  typedef enum logic [1:0] {
    PK_ERASE  = 2'd0,
    PK_HEADER = 2'd1,
    PK_DATA   = 2'd2,
    PK_JUMP   = 2'd3
  } packet_kind_e;

  // status codes
  typedef enum logic [STAT_W-1:0] {
    ST_IDLE        = 4'd0,
    ST_ERASE       = 4'd1,
    ST_HEADER      = 4'd2,
    ST_DATA        = 4'd3,
    ST_DONE        = 4'd4,
    ST_ERASE_TOUT  = 4'd5,
    ST_HEADER_TOUT = 4'd6,
    ST_DATA_TOUT   = 4'd7,
    ST_CANCELLED   = 4'd8
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IMAGE_SIZE = 2'd0,
    CFG_IMAGE_CRC  = 2'd1,
    CFG_BOOT_MODE  = 2'd2
  } cfg_index_e;

endpackage

// ----- rtl/firmware_upload_sequencer.sv -----
// ----------------------------------------------------------------------------
// firmware_upload_sequencer: firmware image upload sequencer
// Steps an upload through erase, header and data chunk phases (bootloader mode
// starts at data), with reply timer and retries; one packet descriptor per item.
// ----------------------------------------------------------------------------
// Pipeline: an accepted item waits in the input register, and the sequencer
// state and result registers update from it when it fires.
// Throughput: one item per cycle while the result is taken; each item sees
// the state the previous one left, as the state registers update on each fire.
// Reset: all control state clears at once; image size resets to 1, CRC and
// bootloader mode to 0; no clearing pass.
module firmware_upload_sequencer #(
  parameter int unsigned CHUNK_BYTES         = fwu_pkg::CHUNK_BYTES_DEF,
  parameter int unsigned RETRY_LIMIT         = fwu_pkg::RETRY_LIMIT_DEF,
  parameter int unsigned REPLY_TIMEOUT_TICKS = fwu_pkg::REPLY_TIMEOUT_TICKS_DEF,
  parameter int unsigned START_TIMEOUT_TICKS = fwu_pkg::START_TIMEOUT_TICKS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [fwu_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [fwu_pkg::SIZE_W-1:0]      cfg_data_i,
  // event input channel
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [1:0]                      kind_i,
  input  logic                            reply_ok_i,
  // result channel
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            send_valid_o,
  output logic [1:0]                      packet_kind_o,
  output logic [fwu_pkg::SIZE_W-1:0]      packet_offset_o,
  output logic [fwu_pkg::SIZE_W-1:0]      packet_length_o,
  output logic [fwu_pkg::CRC_W-1:0]       packet_crc_o,
  output logic [fwu_pkg::READ_W-1:0]      read_offset_o,
  output logic                            uploading_o,
  output logic [fwu_pkg::STAT_W-1:0]      status_code_o,
  output logic [fwu_pkg::SIZE_W-1:0]      bytes_done_o
);

  localparam int unsigned SW = fwu_pkg::SIZE_W;
  localparam int unsigned TimerMax = (REPLY_TIMEOUT_TICKS > START_TIMEOUT_TICKS) ?
                                     REPLY_TIMEOUT_TICKS : START_TIMEOUT_TICKS;
  localparam int unsigned TimerW = $clog2(TimerMax + 1);
  localparam int unsigned RetryW = $clog2(RETRY_LIMIT + 1);

  localparam logic [SW-1:0]     Chunk       = SW'(CHUNK_BYTES);
  localparam logic [TimerW-1:0] TimerReply  = TimerW'(REPLY_TIMEOUT_TICKS);
  localparam logic [TimerW-1:0] TimerStart  = TimerW'(START_TIMEOUT_TICKS);
  localparam logic [RetryW-1:0] RetryFull   = RetryW'(RETRY_LIMIT);
  localparam logic [RetryW-1:0] RetryReload = RetryW'(RETRY_LIMIT - 1);

  typedef enum logic [1:0] {
    PH_ERASE  = 2'd0,
    PH_HEADER = 2'd1,
    PH_DATA   = 2'd2
  } phase_e;

  // configuration registers
  logic [SW-1:0]                 cfg_size_q;
  logic [fwu_pkg::CRC_W-1:0]     cfg_crc_q;
  logic                          cfg_boot_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_size_q <= SW'(1);
      cfg_crc_q  <= '0;
      cfg_boot_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (fwu_pkg::cfg_index_e'(cfg_index_i))
        fwu_pkg::CFG_IMAGE_SIZE: cfg_size_q <= cfg_data_i;
        fwu_pkg::CFG_IMAGE_CRC:  cfg_crc_q  <= cfg_data_i[fwu_pkg::CRC_W-1:0];
        fwu_pkg::CFG_BOOT_MODE:  cfg_boot_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic                  in_valid_q;
  fwu_pkg::event_kind_e  kind_q;
  logic                  ok_q;
  logic                  out_valid_q;
  logic                  adv_en;
  logic                  fire;

  assign adv_en     = !out_valid_q || out_ready_i;
  assign fire       = in_valid_q && adv_en;
  assign in_ready_o = !in_valid_q || adv_en;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      kind_q     <= fwu_pkg::EV_START;
      ok_q       <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
      if (in_valid_i) begin
        kind_q <= fwu_pkg::event_kind_e'(kind_i);
        ok_q   <= reply_ok_i;
      end
    end
  end

  // sequencer state
  logic                      active_q, active_d;
  phase_e                    phase_q, phase_d;
  logic [TimerW-1:0]         timer_q, timer_d;
  logic [RetryW-1:0]         retries_q, retries_d;
  logic [SW-1:0]             bp_q, bp_d;
  fwu_pkg::status_e          status_q, status_d;
  logic [SW-1:0]             run_size_q, run_size_d;
  logic [fwu_pkg::CRC_W-1:0] run_crc_q, run_crc_d;
  logic                      run_boot_q, run_boot_d;

  // result register
  logic                      send_q, send_d;
  fwu_pkg::packet_kind_e     pkind_q, pkind_d;
  logic [SW-1:0]             off_q, off_d;
  logic [SW-1:0]             len_q, len_d;
  logic [fwu_pkg::CRC_W-1:0] crc_q, crc_d;
  logic [fwu_pkg::READ_W-1:0] read_q, read_d;

  // chunk geometry
  logic          is_start;
  logic          adv_step;
  logic [SW-1:0] size_sat;
  logic [SW-1:0] bp_adv;
  logic [SW-1:0] chunk_base;
  logic [SW-1:0] chunk_size;
  logic          chunk_boot;
  logic [SW-1:0] chunk_left;
  logic [SW-1:0] chunk_len;
  logic [SW-1:0] chunk_off;

  assign is_start   = (kind_q == fwu_pkg::EV_START);
  assign adv_step   = (kind_q == fwu_pkg::EV_REPLY) && ok_q && (phase_q == PH_DATA);
  assign size_sat   = (cfg_size_q > fwu_pkg::MAX_IMAGE_BYTES) ?
                      fwu_pkg::MAX_IMAGE_BYTES : cfg_size_q;
  assign bp_adv     = bp_q + Chunk;
  assign chunk_base = is_start ? '0 : (adv_step ? bp_adv : bp_q);
  assign chunk_size = is_start ? size_sat : run_size_q;
  assign chunk_boot = is_start ? cfg_boot_q : run_boot_q;
  assign chunk_left = (chunk_size > chunk_base) ? (chunk_size - chunk_base) : '0;
  assign chunk_len  = (chunk_left > Chunk) ? Chunk : chunk_left;
  assign chunk_off  = chunk_base + (chunk_boot ? fwu_pkg::BOOT_OFFSET : fwu_pkg::APP_OFFSET);

  // next state and packet selection
  logic do_adv;
  logic adv_to;

  always_comb begin
    active_d   = active_q;
    phase_d    = phase_q;
    timer_d    = timer_q;
    retries_d  = retries_q;
    bp_d       = bp_q;
    status_d   = status_q;
    run_size_d = run_size_q;
    run_crc_d  = run_crc_q;
    run_boot_d = run_boot_q;
    send_d     = 1'b0;
    pkind_d    = fwu_pkg::PK_ERASE;
    do_adv     = 1'b0;
    adv_to     = 1'b1;

    case (kind_q)
      fwu_pkg::EV_START: begin
        run_size_d = size_sat;
        run_crc_d  = cfg_crc_q;
        run_boot_d = cfg_boot_q;
        active_d   = 1'b1;
        bp_d       = '0;
        send_d     = 1'b1;
        if (cfg_boot_q) begin
          phase_d   = PH_DATA;
          status_d  = fwu_pkg::ST_DATA;
          retries_d = RetryReload;
          timer_d   = TimerReply;
          pkind_d   = fwu_pkg::PK_DATA;
        end else begin
          phase_d   = PH_ERASE;
          status_d  = fwu_pkg::ST_ERASE;
          retries_d = RetryFull;
          timer_d   = TimerStart;
          pkind_d   = fwu_pkg::PK_ERASE;
        end
      end
      fwu_pkg::EV_TICK: begin
        if (active_q) begin
          if (timer_q != '0) begin
            timer_d = timer_q - TimerW'(1);
          end else begin
            do_adv = 1'b1;
          end
        end
      end
      fwu_pkg::EV_REPLY: begin
        do_adv = 1'b1;
        adv_to = !ok_q;
      end
      fwu_pkg::EV_CANCEL: begin
        if (active_q) begin
          active_d = 1'b0;
          bp_d     = '0;
          phase_d  = PH_ERASE;
          status_d = fwu_pkg::ST_CANCELLED;
        end
      end
      default: ;
    endcase

    // reply or timeout handling per phase
    if (do_adv && active_q) begin
      case (phase_q)
        PH_ERASE: begin
          if (adv_to) begin
            active_d = 1'b0;
            bp_d     = '0;
            phase_d  = PH_ERASE;
            status_d = fwu_pkg::ST_ERASE_TOUT;
          end else begin
            phase_d   = PH_HEADER;
            status_d  = fwu_pkg::ST_HEADER;
            retries_d = RetryReload;
            timer_d   = TimerReply;
            send_d    = 1'b1;
            pkind_d   = fwu_pkg::PK_HEADER;
          end
        end
        PH_HEADER: begin
          if (adv_to) begin
            if (retries_q == '0) begin
              active_d = 1'b0;
              bp_d     = '0;
              phase_d  = PH_ERASE;
              status_d = fwu_pkg::ST_HEADER_TOUT;
            end else begin
              status_d  = fwu_pkg::ST_HEADER;
              retries_d = retries_q - RetryW'(1);
              timer_d   = TimerReply;
              send_d    = 1'b1;
              pkind_d   = fwu_pkg::PK_HEADER;
            end
          end else begin
            phase_d   = PH_DATA;
            status_d  = fwu_pkg::ST_DATA;
            retries_d = RetryReload;
            timer_d   = TimerReply;
            send_d    = 1'b1;
            pkind_d   = fwu_pkg::PK_DATA;
          end
        end
        PH_DATA: begin
          if (adv_to) begin
            if (retries_q == '0) begin
              active_d = 1'b0;
              bp_d     = '0;
              phase_d  = PH_ERASE;
              status_d = fwu_pkg::ST_DATA_TOUT;
            end else begin
              status_d  = fwu_pkg::ST_DATA;
              retries_d = retries_q - RetryW'(1);
              timer_d   = TimerReply;
              send_d    = 1'b1;
              pkind_d   = fwu_pkg::PK_DATA;
            end
          end else if (bp_adv >= run_size_q) begin
            // last chunk acknowledged
            active_d = 1'b0;
            bp_d     = '0;
            phase_d  = PH_ERASE;
            status_d = fwu_pkg::ST_DONE;
            send_d   = !run_boot_q;
            pkind_d  = fwu_pkg::PK_JUMP;
          end else begin
            status_d  = fwu_pkg::ST_DATA;
            bp_d      = bp_adv;
            retries_d = RetryReload;
            timer_d   = TimerReply;
            send_d    = 1'b1;
            pkind_d   = fwu_pkg::PK_DATA;
          end
        end
        default: ;
      endcase
    end

    // packet fields, zero when nothing is sent
    off_d  = '0;
    len_d  = '0;
    crc_d  = '0;
    read_d = '0;
    if (send_d) begin
      case (pkind_d)
        fwu_pkg::PK_ERASE: len_d = chunk_size;
        fwu_pkg::PK_HEADER: begin
          len_d = run_size_q;
          crc_d = run_crc_q;
        end
        fwu_pkg::PK_DATA: begin
          off_d  = chunk_off;
          len_d  = chunk_len;
          read_d = chunk_base[fwu_pkg::READ_W-1:0];
        end
        default: ;
      endcase
    end else begin
      pkind_d = fwu_pkg::PK_ERASE;
    end
  end

  // state and result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      phase_q     <= PH_ERASE;
      timer_q     <= '0;
      retries_q   <= '0;
      bp_q        <= '0;
      status_q    <= fwu_pkg::ST_IDLE;
      run_size_q  <= '0;
      run_crc_q   <= '0;
      run_boot_q  <= 1'b0;
      send_q      <= 1'b0;
      pkind_q     <= fwu_pkg::PK_ERASE;
      off_q       <= '0;
      len_q       <= '0;
      crc_q       <= '0;
      read_q      <= '0;
    end else if (adv_en) begin
      out_valid_q <= in_valid_q;
      if (fire) begin
        active_q   <= active_d;
        phase_q    <= phase_d;
        timer_q    <= timer_d;
        retries_q  <= retries_d;
        bp_q       <= bp_d;
        status_q   <= status_d;
        run_size_q <= run_size_d;
        run_crc_q  <= run_crc_d;
        run_boot_q <= run_boot_d;
        send_q     <= send_d;
        pkind_q    <= pkind_d;
        off_q      <= off_d;
        len_q      <= len_d;
        crc_q      <= crc_d;
        read_q     <= read_d;
      end
    end
  end

  // outputs
  assign out_valid_o     = out_valid_q;
  assign send_valid_o    = send_q;
  assign packet_kind_o   = pkind_q;
  assign packet_offset_o = off_q;
  assign packet_length_o = len_q;
  assign packet_crc_o    = crc_q;
  assign read_offset_o   = read_q;
  assign uploading_o     = active_q;
  assign status_code_o   = status_q;
  assign bytes_done_o    = bp_q;

  // checks
  a_retry_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    retries_q <= RetryFull)
    else $error("retry count above limit");

  a_idle_pointer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !uploading_o |-> bytes_done_o == '0)
    else $error("byte pointer not cleared while idle");

  a_quiet_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !send_valid_o |->
      packet_offset_o == '0 && packet_length_o == '0 && packet_crc_o == '0 &&
      read_offset_o == '0)
    else $error("packet fields set with no packet");

  a_active_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && uploading_o |->
      status_code_o == fwu_pkg::ST_ERASE || status_code_o == fwu_pkg::ST_HEADER ||
      status_code_o == fwu_pkg::ST_DATA)
    else $error("upload running with a final status");

  a_chunk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_valid_o && packet_kind_o == fwu_pkg::PK_DATA |->
      packet_length_o <= Chunk)
    else $error("data chunk longer than chunk size");

endmodule
